>>> hw/rtl/bbn_pkg.sv
// Package for the edge-normalized 3x3 box blur: widths, reset values, register
// indexes, neighbor control type and the reciprocal table used for the divide.
// No dependencies.
package bbn_pkg;

  localparam int CH_W = 8;
  localparam int NCH = 3;
  localparam int PIX_W = CH_W * NCH;

  localparam int CFG_W = 12;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam int DEF_WIDTH = 640;
  localparam int DEF_HEIGHT = 480;
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam logic CMD_FLUSH = 1'b1;

  localparam int CSUM_W = 10;
  localparam int SUM_W = 12;
  localparam int X_W = SUM_W + 1;
  localparam int CNT_W = 4;
  localparam int DIV_SHIFT = 20;
  localparam int RECIP_W = 20;
  localparam int PROD_W = X_W + RECIP_W;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic last;
  } nbr_ctrl_t;

  function automatic logic [CNT_W-1:0] nbr_count(nbr_ctrl_t c);
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;
    rows = CNT_W'(1) + CNT_W'(c.top_ok) + CNT_W'(c.bot_ok);
    cols = CNT_W'(1) + CNT_W'(c.left_ok) + CNT_W'(c.right_ok);
    return CNT_W'(rows * cols);
  endfunction

  // Scaled reciprocal of 2*n; exact for every rounded-mean numerator.
  function automatic logic [RECIP_W-1:0] recip_of(logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] m;
    unique case (n)
      4'd1:    m = 20'd524288;
      4'd2:    m = 20'd262144;
      4'd3:    m = 20'd174763;
      4'd4:    m = 20'd131072;
      4'd6:    m = 20'd87382;
      4'd9:    m = 20'd58255;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

>>> hw/rtl/bbn_ram.sv
// Generic single-write, single-read RAM with a registered, read-first read port.
// Depends on bbn_pkg for default sizes.
module bbn_ram
  import bbn_pkg::*;
#(
  parameter int WIDTH = PIX_W,
  parameter int DEPTH = DEF_MAX_WIDTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/box_blur_3x3_edge_normalized.sv
// Streaming 3x3 box blur with edge-normalized, rounded means over RGB pixels.
// Depends on bbn_pkg and bbn_ram.
//
// Pixels enter in raster order and each output word is the mean of the pixel's
// 3x3 neighborhood, counting only neighbors inside the frame (corners divide by
// 4, edges by 6, interior by 9), rounded to nearest with halves going up. The
// block takes one word per clock and sustains one result per clock while the
// output is not stalled; there is no clearing pass after reset. Result k leaves
// once input word k+W+1 is in, so after the last pixel of a frame send W+1
// flush words (tuser high), after which the last result carries tlast and all
// positions restart. A flush word inside the frame stands for a black pixel; a
// pixel beyond the frame is dropped. A result is registered in turn through the
// line-store read, window, sum, scale, multiply and output registers. Writing
// either size register restarts the frame; sizes are clamped to 1..MAX.
module box_blur_3x3_edge_normalized
  import bbn_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [PIX_W-1:0]     in_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
  input  logic                 in_tuser,   // command
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [PIX_W-1:0]     out_tdata,  // red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic                 out_tlast
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int CMPW = (WW > CFG_W) ? WW : CFG_W;
  localparam int CMPH = (HW > CFG_W) ? HW : CFG_W;
  localparam logic [WW-1:0] W_RST = WW'((DEF_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEF_WIDTH);
  localparam logic [HW-1:0] H_RST = HW'((DEF_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : DEF_HEIGHT);

  logic [WW-1:0] w_r, w_nxt, w_clamp;
  logic [HW-1:0] h_r, h_nxt, h_clamp;
  logic [CMPW-1:0] w_ext;
  logic [CMPH-1:0] h_ext;

  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [1:0]    in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [HW-1:0] out_row_r, out_row_nxt;

  logic      restart;
  logic      in_fire;
  logic      emit0;
  nbr_ctrl_t ctrl0;

  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt, v4_r, v4_nxt, v5_r, v5_nxt;
  logic out_v_r, out_v_nxt;
  logic adv1, adv2, adv3, adv4, adv5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, out_rdy;

  pixel_t        pix1_r;
  logic [CW-1:0] col1_r;
  logic          emit1_r;
  nbr_ctrl_t     ctrl1_r;
  logic          byp1_r;
  pixel_t        bypa_r, bypb_r;
  pixel_t        rd0, rd1, a1, b1;

  pixel_t    win_r [3][3];
  nbr_ctrl_t ctrl2_r;

  logic [CSUM_W-1:0] csum_r [3][NCH];
  logic [CNT_W-1:0]  n3_r;
  nbr_ctrl_t         ctrl3_r;

  logic [X_W-1:0]     x4_r [NCH];
  logic [RECIP_W-1:0] m4_r;
  logic               last4_r;

  logic [PROD_W-1:0] prod5_r [NCH];
  logic              last5_r;

  pixel_t out_data_r;
  logic   out_last_r;

  // Size registers
  always_comb begin
    w_ext = CMPW'(cfg_wdata);
    h_ext = CMPH'(cfg_wdata);
    if (w_ext == '0) begin
      w_clamp = WW'(1);
    end else if (w_ext > CMPW'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(w_ext);
    end
    if (h_ext == '0) begin
      h_clamp = HW'(1);
    end else if (h_ext > CMPH'(MAX_HEIGHT)) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(h_ext);
    end
  end

  // Position tracking at the input
  always_comb begin
    emit0 = (in_row_r == 2'd2) || (in_row_r == 2'd1 && in_col_r != '0);
    ctrl0.top_ok = (out_row_r != '0);
    ctrl0.bot_ok = ((out_row_r + HW'(1)) < h_r);
    ctrl0.left_ok = (out_col_r != '0);
    ctrl0.right_ok = ((WW'(out_col_r) + WW'(1)) < w_r);
    ctrl0.last = (WW'(out_col_r) == w_r - WW'(1)) && (out_row_r == h_r - HW'(1));
  end

  always_comb begin
    w_nxt = w_r;
    h_nxt = h_r;
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    restart = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          w_nxt = w_clamp;
          restart = 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          h_nxt = h_clamp;
          restart = 1'b1;
        end
        default: ;
      endcase
    end else if (in_fire && emit0 && ctrl0.last) begin
      restart = 1'b1;
    end
    if (restart) begin
      in_col_nxt = '0;
      in_row_nxt = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (in_fire) begin
      if (WW'(in_col_r) == w_r - WW'(1)) begin
        in_col_nxt = '0;
        if (in_row_r != 2'd2) begin
          in_row_nxt = in_row_r + 2'd1;
        end
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (emit0) begin
        if (!ctrl0.right_ok) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + HW'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
  end

  // Pipeline flow
  always_comb begin
    out_rdy = !out_v_r || out_tready;
    adv5 = v5_r && out_rdy;
    rdy5 = !v5_r || out_rdy;
    adv4 = v4_r && rdy5;
    rdy4 = !v4_r || rdy5;
    adv3 = v3_r && rdy4;
    rdy3 = !v3_r || rdy4;
    adv2 = v2_r && rdy3;
    rdy2 = !v2_r || rdy3;
    adv1 = v1_r && rdy2;
    rdy1 = !v1_r || rdy2;
    in_fire = in_tvalid && rdy1;

    v1_nxt = in_fire ? 1'b1 : (adv1 ? 1'b0 : v1_r);
    v2_nxt = adv1 ? emit1_r : (adv2 ? 1'b0 : v2_r);
    v3_nxt = adv2 ? 1'b1 : (adv3 ? 1'b0 : v3_r);
    v4_nxt = adv3 ? 1'b1 : (adv4 ? 1'b0 : v4_r);
    v5_nxt = adv4 ? 1'b1 : (adv5 ? 1'b0 : v5_r);
    out_v_nxt = adv5 ? 1'b1 : (out_tready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= W_RST;
      h_r <= H_RST;
      in_col_r <= '0;
      in_row_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      w_r <= w_nxt;
      h_r <= h_nxt;
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
      v5_r <= v5_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Line stores: store 0 holds the row above, store 1 the row two above.
  bbn_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_row_above (
    .clk  (clk),
    .we   (adv1),
    .waddr(col1_r),
    .wdata(pix1_r),
    .re   (in_fire),
    .raddr(in_col_r),
    .rdata(rd0)
  );

  bbn_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_row_prev (
    .clk  (clk),
    .we   (adv1),
    .waddr(col1_r),
    .wdata(a1),
    .re   (in_fire),
    .raddr(in_col_r),
    .rdata(rd1)
  );

  // A word that reads the column being written in the same cycle takes the
  // write data instead of the stale memory word.
  always_comb begin
    a1 = byp1_r ? bypa_r : rd0;
    b1 = byp1_r ? bypb_r : rd1;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pix1_r <= (in_tuser == CMD_FLUSH) ? '0 : in_tdata;
      col1_r <= in_col_r;
      emit1_r <= emit0;
      ctrl1_r <= ctrl0;
      byp1_r <= adv1 && (col1_r == in_col_r);
      bypa_r <= pix1_r;
      bypb_r <= a1;
    end
  end

  // Window shift
  always_ff @(posedge clk) begin
    if (adv1) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2][0] <= b1;
      win_r[2][1] <= a1;
      win_r[2][2] <= pix1_r;
      ctrl2_r <= ctrl1_r;
    end
  end

  // Column sums with row masking
  always_ff @(posedge clk) begin
    if (adv2) begin
      for (int j = 0; j < 3; j++) begin
        for (int ch = 0; ch < NCH; ch++) begin
          csum_r[j][ch] <=
            (ctrl2_r.top_ok ? CSUM_W'(win_r[j][0][ch*CH_W +: CH_W]) : CSUM_W'(0)) +
            CSUM_W'(win_r[j][1][ch*CH_W +: CH_W]) +
            (ctrl2_r.bot_ok ? CSUM_W'(win_r[j][2][ch*CH_W +: CH_W]) : CSUM_W'(0));
        end
      end
      n3_r <= nbr_count(ctrl2_r);
      ctrl3_r <= ctrl2_r;
    end
  end

  // Rounded-mean numerator 2*sum + n and the reciprocal of 2*n
  always_ff @(posedge clk) begin
    if (adv3) begin
      for (int ch = 0; ch < NCH; ch++) begin
        x4_r[ch] <= {(ctrl3_r.left_ok ? SUM_W'(csum_r[0][ch]) : SUM_W'(0)) +
                     SUM_W'(csum_r[1][ch]) +
                     (ctrl3_r.right_ok ? SUM_W'(csum_r[2][ch]) : SUM_W'(0)), 1'b0} +
                    X_W'(n3_r);
      end
      m4_r <= recip_of(n3_r);
      last4_r <= ctrl3_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      for (int ch = 0; ch < NCH; ch++) begin
        prod5_r[ch] <= PROD_W'(x4_r[ch]) * PROD_W'(m4_r);
      end
      last5_r <= last4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      for (int ch = 0; ch < NCH; ch++) begin
        out_data_r[ch*CH_W +: CH_W] <= prod5_r[ch][DIV_SHIFT +: CH_W];
      end
      out_last_r <= last5_r;
    end
  end

  assign in_tready = rdy1;
  assign out_tvalid = out_v_r;
  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;

`ifndef NO_ASSERTIONS
  a_out_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_row_r < h_r) && (WW'(out_col_r) < w_r))
    else $error("output position left the frame");

  a_divisor_known: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (m4_r != '0))
    else $error("neighbor count outside the corner, edge and interior set");

  a_mean_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> ((prod5_r[0][PROD_W-1:DIV_SHIFT+CH_W] == '0) &&
              (prod5_r[1][PROD_W-1:DIV_SHIFT+CH_W] == '0) &&
              (prod5_r[2][PROD_W-1:DIV_SHIFT+CH_W] == '0)))
    else $error("scaled mean exceeds one channel");
`endif

endmodule

>>> test/box_blur_3x3_edge_normalized_tb.sv
// Testbench for box_blur_3x3_edge_normalized: streams RGB frames, predicts each edge-normalized
// blurred word and checks every result under random source and sink stalls, then at full rate.
// Depends on bbn_pkg and the box_blur_3x3_edge_normalized RTL.
module box_blur_3x3_edge_normalized_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bbn_pkg::*;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int MAX_W = DEF_MAX_WIDTH;
  localparam int MAX_H = DEF_MAX_HEIGHT;
  localparam int DRAIN_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS = 320;
  localparam int REPORT_LIMIT = 100;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

  typedef struct {
    rgb_t px;
    logic last;
  } blur_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [PIX_W-1:0] in_tdata = '0;   // red_in[7:0], green_in[15:8], blue_in[23:16]
  logic in_tuser = 1'b0;             // command
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [PIX_W-1:0] out_tdata;       // red_out[7:0], green_out[15:8], blue_out[23:16]
  logic out_tlast;                   // frame_end

  box_blur_3x3_edge_normalized DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #6 clk = ~clk;

  // Blur predictor state: four rotating line stores, the size registers and the positions.
  rgb_t line_ring [4][MAX_W];
  logic [CFG_W-1:0] width_reg = CFG_W'(DEF_WIDTH);
  logic [CFG_W-1:0] height_reg = CFG_W'(DEF_HEIGHT);
  int unsigned in_col = 0;
  int unsigned in_row = 0;
  int unsigned out_col = 0;
  int unsigned out_row = 0;
  blur_word_t expected_blur [$];

  bit gaps_on = 1'b1;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned frames_seen = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  blur_word_t want;
  rgb_t got;

  initial begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < MAX_W; c++) begin
        line_ring[r][c] = '0;
      end
    end
  end

  function automatic int unsigned frame_dim(input logic [CFG_W-1:0] v, input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void blur_predict(input logic cmd, input rgb_t px);
    int unsigned w, h, ticks, target, n, sr, sg, sb;
    rgb_t nb;
    blur_word_t res;
    w = frame_dim(width_reg, MAX_W);
    h = frame_dim(height_reg, MAX_H);
    if (in_row < h && in_col < w) begin
      line_ring[in_row % 4][in_col] = (cmd == CMD_FLUSH) ? rgb_t'('0) : px;
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    ticks = in_row * w + in_col;
    target = out_row * w + out_col + w + 2;
    if (out_row >= h || ticks < target) return;
    n = 0;
    sr = 0;
    sg = 0;
    sb = 0;
    for (int r = int'(out_row) - 1; r <= int'(out_row) + 1; r++) begin
      if (r >= 0 && r < int'(h)) begin
        for (int c = int'(out_col) - 1; c <= int'(out_col) + 1; c++) begin
          if (c >= 0 && c < int'(w)) begin
            nb = line_ring[r % 4][c];
            sr += nb.red;
            sg += nb.green;
            sb += nb.blue;
            n++;
          end
        end
      end
    end
    res.px.red = CH_W'((2 * sr + n) / (2 * n));
    res.px.green = CH_W'((2 * sg + n) / (2 * n));
    res.px.blue = CH_W'((2 * sb + n) / (2 * n));
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    res.last = 1'b0;
    if (out_row >= h) begin
      res.last = 1'b1;
      restart_frame();
    end
    expected_blur.push_back(res);
  endfunction

  function automatic rgb_t rand_px();
    return PIX_W'($urandom);
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return CFG_W'($urandom_range(11, 24));
      default: return CFG_W'($urandom_range(1, 10));
    endcase
  endfunction

  task automatic send_word(input logic cmd, input rgb_t px);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    blur_predict(cmd, px);
    words_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) begin
      width_reg = val;
      restart_frame();
    end else if (idx == REG_IMAGE_HEIGHT) begin
      height_reg = val;
      restart_frame();
    end
  endtask

  task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_write(REG_IMAGE_WIDTH, w);
    cfg_write(REG_IMAGE_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_blur.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One whole frame at the current size followed by its drain words.
  task automatic send_frame(input int unsigned flush_odds);
    int unsigned w, h;
    w = frame_dim(width_reg, MAX_W);
    h = frame_dim(height_reg, MAX_H);
    for (int unsigned i = 0; i < w * h; i++) begin
      if (flush_odds != 0 && $urandom_range(1, flush_odds) == 1) send_word(CMD_FLUSH, rand_px());
      else send_word(CMD_PIXEL, rand_px());
    end
    for (int unsigned i = 0; i <= w; i++) begin
      send_word(logic'($urandom_range(0, 1)), rand_px());
    end
  endtask

  task automatic test_reset_size();
    repeat (DEF_WIDTH + 5) send_word(CMD_PIXEL, rand_px());
    settle();
  endtask

  task automatic test_edge_cases();
    rgb_t px;
    logic cmd;
    set_size(3, 3);
    for (int i = 0; i < 13; i++) begin
      px = (i % 2 == 0) ? rgb_t'('1) : rgb_t'('0);
      if (i == 8) px = '{blue: 8'h80, green: 8'h00, red: 8'hFF};
      if (i < 9) cmd = (i == 4) ? CMD_FLUSH : CMD_PIXEL;
      else cmd = (i % 2 == 1) ? CMD_PIXEL : CMD_FLUSH;
      send_word(cmd, px);
    end
    settle();
    set_size(0, 0);
    send_word(CMD_PIXEL, '1);
    send_word(CMD_PIXEL, '1);
    send_word(CMD_FLUSH, '1);
    settle();
    set_size(2, 1);
    send_frame(0);
    settle();
    set_size(1, 3);
    send_frame(0);
    settle();
  endtask

  // A zero on one axis only; the other axis keeps its own size.
  task automatic test_size_limits();
    set_size(0, 3);
    send_frame(0);
    settle();
    set_size(4, 0);
    send_frame(0);
    settle();
  endtask

  // Writes to indexes past the register list must leave a frame in progress untouched.
  task automatic test_spare_index();
    set_size(5, 4);
    repeat (10) send_word(CMD_PIXEL, rand_px());
    settle();
    cfg_write(REG_SPARE_A, '1);
    cfg_write(REG_SPARE_B, 12'h5A5);
    cfg_we <= 1'b0;
    repeat (10) send_word(CMD_PIXEL, rand_px());
    repeat (6) send_word(logic'($urandom_range(0, 1)), rand_px());
    settle();
  endtask

  task automatic test_random_frames();
    int unsigned start, mode, total, cut;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      mode = $urandom_range(0, 9);
      set_size(pick_dim(), pick_dim());
      if (mode < 7) begin
        repeat ($urandom_range(1, 2)) send_frame(16);
      end else if (mode < 8) begin
        repeat ($urandom_range(1, 30)) send_word(logic'($urandom_range(0, 1)), rand_px());
      end else begin
        total = frame_dim(width_reg, MAX_W) * (frame_dim(height_reg, MAX_H) + 1) + 1;
        cut = $urandom_range(1, total - 1);
        repeat (cut) send_word(($urandom_range(0, 7) == 0) ? CMD_FLUSH : CMD_PIXEL, rand_px());
      end
      settle();
    end
  endtask

  task automatic test_full_rate();
    gaps_on = 1'b0;
    set_size(8, 6);
    repeat (3) send_frame(0);
    settle();
  endtask

  task automatic report(input string field, input int exp_v, input int act_v);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $error("%s: expected %0d, got %0d", field, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_blur.size() == 0) begin
        report("unexpected word", 0, 1);
      end else begin
        want = expected_blur.pop_front();
        got = out_tdata;
        if (got.red !== want.px.red) report("red_out", want.px.red, got.red);
        if (got.green !== want.px.green) report("green_out", want.px.green, got.green);
        if (got.blue !== want.px.blue) report("blue_out", want.px.blue, got.blue);
        if (out_tlast !== want.last) report("frame_end", want.last, out_tlast);
        if (want.last) frames_seen++;
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    forever begin
      repeat ($urandom_range(1, 60)) begin
        @(posedge clk);
        out_tready <= 1'b1;
      end
      if (gaps_on && $urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 18)) begin
          @(posedge clk);
          out_tready <= 1'b0;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_size();
    test_edge_cases();
    test_size_limits();
    test_spare_index();
    test_random_frames();
    test_full_rate();
    $display("Checked %0d blurred words in %0d completed frames from %0d input words.",
             words_checked, frames_seen, words_sent);
    $display("Run covered reset size, clamped sizes, flush and drain words and random framing.");
    if (mismatches == 0 && expected_blur.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/bbn_pkg.sv
hw/rtl/bbn_ram.sv
hw/rtl/box_blur_3x3_edge_normalized.sv
test/box_blur_3x3_edge_normalized_tb.sv
